// ===== sv/domain_name_validator_assert.svh =====
// ----------------------------------------------------------------------------
// domain name validator assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef DOMAIN_NAME_VALIDATOR_ASSERT_SVH
`define DOMAIN_NAME_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define DNV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnv assertion failed");

// next-cycle implication
`define DNV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnv assertion failed");

`endif

// ===== sv/dnv_pkg.sv =====
// ----------------------------------------------------------------------------
// dnv_pkg
// types and constants shared by the host name checker modules
// ----------------------------------------------------------------------------
package dnv_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [8:0] BYTE_COUNT_MAX  = 9'd511;
	localparam logic [6:0] LABEL_COUNT_MAX = 7'd127;
	localparam logic [7:0] NAME_LEN_RESET  = 8'd255;
	localparam logic [5:0] LABEL_LEN_RESET = 6'd63;

	typedef enum logic {
		REG_MAX_NAME_LEN  = 1'b0,
		REG_MAX_LABEL_LEN = 1'b1
	} reg_idx_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic letter;
		logic digit;
		logic dot;
		logic hyphen;
		logic last;
	} byte_class_t;

endpackage

// ===== sv/dnv_front.sv =====
// ----------------------------------------------------------------------------
// dnv_front
// accepts name bytes and registers their character class
// ----------------------------------------------------------------------------
module dnv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [7:0]           name_byte,
	input  logic                 is_final,
	output logic                 push_valid,
	input  logic                 push_ready,
	output dnv_pkg::byte_class_t push_class
);
	import dnv_pkg::*;

	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

	logic        valid_s1;
	byte_class_t class_s1;
	byte_class_t class_d;
	logic        load;

	always_comb begin
		class_d.letter = ((name_byte >= 8'h41) && (name_byte <= 8'h5A)) ||
		                 ((name_byte >= 8'h61) && (name_byte <= 8'h7A));
		class_d.digit  = (name_byte >= 8'h30) && (name_byte <= 8'h39);
		class_d.dot    = (name_byte == CHAR_DOT);
		class_d.hyphen = (name_byte == CHAR_HYPHEN);
		class_d.last   = is_final;
	end

	assign item_ready = !valid_s1 || push_ready;
	assign load       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			class_s1 <= class_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_class = class_s1;

endmodule

// ===== sv/dnv_queue.sv =====
// ----------------------------------------------------------------------------
// dnv_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module dnv_queue #(
	parameter int QueueDepth = dnv_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  dnv_pkg::byte_class_t push_class,
	output logic                 pop_valid,
	input  logic                 pop,
	output dnv_pkg::byte_class_t pop_class
);
	import dnv_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] FullCnt  = CntW'(QueueDepth);

	byte_class_t     slot_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign pop_valid  = (count_q != '0);
	assign do_pop     = pop && pop_valid;
	// a slot freed by this cycle's pop can take the next request
	assign push_ready = (count_q != FullCnt) || do_pop;
	assign do_push    = push_valid && push_ready;
	assign pop_class  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_class;
		end
	end

endmodule

// ===== sv/dnv_back.sv =====
// ----------------------------------------------------------------------------
// dnv_back
// per-name counters and checks, verdict output register
// ----------------------------------------------------------------------------
module dnv_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop,
	input  dnv_pkg::byte_class_t pop_class,
	input  logic [7:0]           max_name_len,
	input  logic [5:0]           max_label_len,
	output logic                 verdict_valid,
	input  logic                 verdict_ready,
	output logic                 name_ok
);
	import dnv_pkg::*;

	logic [8:0] byte_cnt_q;
	logic [6:0] label_cnt_q;
	logic       saw_dot_q;
	logic       failed_q;
	logic       out_valid_q;
	logic       name_ok_q;

	logic       alnum;
	logic       fail_d;
	logic [8:0] byte_d;
	logic [6:0] label_d;
	logic       dot_d;
	logic       verdict_fail;
	logic [6:0] label_lim;
	logic       slot_free;

	assign label_lim = {1'b0, max_label_len};
	assign slot_free = !out_valid_q || verdict_ready;
	// only a final byte needs the output slot
	assign pop       = pop_valid && (!pop_class.last || slot_free);

	always_comb begin
		alnum   = pop_class.letter || pop_class.digit;
		fail_d  = failed_q || !(alnum || pop_class.dot || pop_class.hyphen) ||
		          ((byte_cnt_q == '0) && !pop_class.letter);
		byte_d  = (byte_cnt_q == BYTE_COUNT_MAX) ? byte_cnt_q : byte_cnt_q + 9'd1;
		dot_d   = saw_dot_q;
		label_d = label_cnt_q;
		if (pop_class.dot) begin
			if ((label_cnt_q == '0) || (label_cnt_q > label_lim)) begin
				fail_d = 1'b1;
			end
			dot_d   = 1'b1;
			label_d = '0;
		end else if (label_cnt_q != LABEL_COUNT_MAX) begin
			label_d = label_cnt_q + 7'd1;
		end
		verdict_fail = fail_d || !alnum || (label_d > label_lim) || !dot_d ||
		               (byte_d > {1'b0, max_name_len});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			label_cnt_q <= '0;
			saw_dot_q   <= 1'b0;
			failed_q    <= 1'b0;
		end else if (pop) begin
			if (pop_class.last) begin
				byte_cnt_q  <= '0;
				label_cnt_q <= '0;
				saw_dot_q   <= 1'b0;
				failed_q    <= 1'b0;
			end else begin
				byte_cnt_q  <= byte_d;
				label_cnt_q <= label_d;
				saw_dot_q   <= dot_d;
				failed_q    <= fail_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && pop_class.last) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_class.last) begin
			name_ok_q <= !verdict_fail;
		end
	end

	assign verdict_valid = out_valid_q;
	assign name_ok       = name_ok_q;

endmodule

// ===== sv/domain_name_validator.sv =====
// ----------------------------------------------------------------------------
// domain_name_validator
// host name syntax check, one byte per request, verdict on the final byte
// ----------------------------------------------------------------------------
// channel   handshake                     payload
// item      item_valid / item_ready       name_byte[7:0], is_final
// verdict   verdict_valid / verdict_ready name_ok
// config    apb psel/penable/pwrite       paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one byte per cycle sustained while the verdict is not stalled; the back stage updates counters per byte
// verdict valid once its final byte has passed the front reg, the queue and the output reg
// a stalled verdict blocks only final bytes; the queue keeps taking bytes until full
// reset clears counters and queue and loads limits 255 and 63
// ----------------------------------------------------------------------------
module domain_name_validator #(
	parameter int QueueDepth = dnv_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dnv_pkg::ADDR_W-1:0] paddr,
	input  logic [dnv_pkg::DATA_W-1:0] pwdata,
	output logic [dnv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic [7:0]                 name_byte,
	input  logic                       is_final,
	output logic                       verdict_valid,
	input  logic                       verdict_ready,
	output logic                       name_ok
);
	import dnv_pkg::*;

	logic [7:0]  max_name_len_q;
	logic [5:0]  max_label_len_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	logic        push_valid;
	logic        push_ready;
	byte_class_t push_class;
	logic        pop_valid;
	logic        pop;
	byte_class_t pop_class;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q  <= NAME_LEN_RESET;
			max_label_len_q <= LABEL_LEN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAX_NAME_LEN:  max_name_len_q  <= pwdata[7:0];
				REG_MAX_LABEL_LEN: max_label_len_q <= pwdata[5:0];
				default:           max_name_len_q  <= max_name_len_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_NAME_LEN:  prdata = {{(DATA_W-8){1'b0}}, max_name_len_q};
			REG_MAX_LABEL_LEN: prdata = {{(DATA_W-6){1'b0}}, max_label_len_q};
			default:           prdata = '0;
		endcase
	end

	dnv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.name_byte  (name_byte),
		.is_final   (is_final),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_class (push_class)
	);

	dnv_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_class (push_class),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_class  (pop_class)
	);

	dnv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop           (pop),
		.pop_class     (pop_class),
		.max_name_len  (max_name_len_q),
		.max_label_len (max_label_len_q),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.name_ok       (name_ok)
	);

endmodule

// ===== sv/dnv_checker.sv =====
// ----------------------------------------------------------------------------
// dnv_checker
// port-level checks on the host name validator, bound to the top level
// ----------------------------------------------------------------------------
`include "domain_name_validator_assert.svh"

module dnv_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [dnv_pkg::ADDR_W-1:0] paddr,
	input logic [dnv_pkg::DATA_W-1:0] pwdata,
	input logic [dnv_pkg::DATA_W-1:0] prdata,
	input logic                       pready,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       is_final,
	input logic                       verdict_valid,
	input logic                       verdict_ready,
	input logic                       name_ok
);
	import dnv_pkg::*;

	// final bytes taken whose verdict is not yet delivered
	logic [3:0] pending_q;
	logic       final_in;
	logic       verdict_out;
	logic       name_wr;

	assign final_in    = item_valid && item_ready && is_final;
	assign verdict_out = verdict_valid && verdict_ready;
	assign name_wr     = psel && penable && pwrite && pready &&
	                     (paddr[2] == REG_MAX_NAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({final_in, verdict_out})
				2'b10:   pending_q <= pending_q + 4'd1;
				2'b01:   pending_q <= pending_q - 4'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	`DNV_ASSERT_NEXT(a_verdict_held, verdict_valid && !verdict_ready,
		verdict_valid && $stable(name_ok))
	`DNV_ASSERT_IMP(a_verdict_has_name, verdict_valid, pending_q != 4'd0)
	`DNV_ASSERT_NEXT(a_name_len_readback, name_wr,
		(paddr[2] != REG_MAX_NAME_LEN) || (prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind domain_name_validator dnv_checker u_dnv_checker (.*);
